// ----- design/local_outlier_patch_detector_core_defines.svh -----
// Assertion macros shared by the local outlier patch detector RTL.
`ifndef LOCAL_OUTLIER_PATCH_DETECTOR_CORE_DEFINES_SVH
`define LOCAL_OUTLIER_PATCH_DETECTOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LOPD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LOPD_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LOPD_ASSERT_CLK(lbl, prop, msg)
`define LOPD_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

// ----- design/lopd_pkg.sv -----
// Types, constants and helper functions for the local outlier patch detector.
`default_nettype none
package lopd_pkg;
  localparam int NUM_W   = 7;
  localparam int SIZE_W  = 14;
  localparam int SHIFT_W = 16;
  localparam int ENTRY_W = 2 * SIZE_W + 2 * SHIFT_W;
  localparam int IDX_W   = 6;
  localparam int WGT_W   = 16;

  localparam logic [1:0] REG_NUM_PATCHES  = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

  typedef struct packed {
    logic [SHIFT_W-1:0] sy;
    logic [SHIFT_W-1:0] sx;
    logic [SIZE_W-1:0]  cy;
    logic [SIZE_W-1:0]  cx;
  } entry_t;

  function automatic logic [SHIFT_W:0] shift_mag(logic [SHIFT_W-1:0] a,
                                                 logic [SHIFT_W-1:0] b);
    logic signed [SHIFT_W:0] d;
    d = $signed({a[SHIFT_W-1], a}) - $signed({b[SHIFT_W-1], b});
    return d[SHIFT_W] ? (SHIFT_W+1)'(-d) : (SHIFT_W+1)'(d);
  endfunction

  function automatic logic [SIZE_W-1:0] size_mag(logic [SIZE_W-1:0] a,
                                                 logic [SIZE_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // exp(-y) in Q30 by a truncated series, raised to the 64th power, into Q0.16
  function automatic logic [WGT_W-1:0] build_weight(logic [63:0] x);
    logic [63:0] y;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    logic [63:0] w;
    y    = x >> 6;
    term = 64'd1 << 30;
    sum  = 64'd1 << 30;
    term = ((term * y) >> 30);
    sum  = sum - term;
    term = ((term * y) >> 30) / 2;
    sum  = sum + term;
    term = ((term * y) >> 30) / 3;
    sum  = sum - term;
    term = ((term * y) >> 30) / 4;
    sum  = sum + term;
    term = ((term * y) >> 30) / 5;
    sum  = sum - term;
    term = ((term * y) >> 30) / 6;
    sum  = sum + term;
    v = sum;
    for (int n = 0; n < 6; n++) begin
      v = (v * v) >> 30;
    end
    w = (v * 64'd65535 + (64'd1 << 29)) >> 30;
    return (w > 64'd65535) ? 16'hFFFF : w[WGT_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- design/local_outlier_patch_detector_core.sv -----
// Top level: patch loader, pair sums and per-patch outlier verdicts.
//
//  channel | dir | handshake         | content
//  in_     | in  | tvalid/tready     | one patch: center and shift
//  out_    | out | tvalid/tready     | one verdict per patch, tlast on final
//  cfg_    | in  | APB psel/penable  | num_patches, frame_width, frame_height
//
// A load costs a read and two squarings on the shared multiplier for each
// earlier patch. After the final load comes setup; then each patch is set
// against each other patch (with a bit-serial divide of the normalized
// offset where needed), besides its own read, the skip of its own slot and
// the final compare.
// rst_n is synchronous; results wait in an output register, a full one
// stalls the sequencer.
`default_nettype none
`include "local_outlier_patch_detector_core_defines.svh"
module local_outlier_patch_detector_core
  import lopd_pkg::*;
#(
  parameter int MAX_PATCHES        = 64,
  parameter int WEIGHT_TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // center_x, center_y, shift_x, shift_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // patch_index, bad
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int AW = $clog2(MAX_PATCHES);
  localparam int IW = $clog2(WEIGHT_TABLE_DEPTH);
  localparam logic [31:0] SCALE = 32'(8 * WEIGHT_TABLE_DEPTH);
  localparam logic [31:0] WDEPTH = 32'(WEIGHT_TABLE_DEPTH);

  typedef enum logic [32:0] {
    S_IDLE   = 33'd1 << 0,
    S_LD_RD  = 33'd1 << 1,
    S_LD_MX  = 33'd1 << 2,
    S_LD_MY  = 33'd1 << 3,
    S_LD_ACC = 33'd1 << 4,
    S_LD_END = 33'd1 << 5,
    S_SU_W   = 33'd1 << 6,
    S_SU_H   = 33'd1 << 7,
    S_SU_D   = 33'd1 << 8,
    S_SU_P   = 33'd1 << 9,
    S_SU_END = 33'd1 << 10,
    S_EV_P   = 33'd1 << 11,
    S_EV_PL  = 33'd1 << 12,
    S_EV_K   = 33'd1 << 13,
    S_EV_DX  = 33'd1 << 14,
    S_EV_DY  = 33'd1 << 15,
    S_EV_NX  = 33'd1 << 16,
    S_EV_NY  = 33'd1 << 17,
    S_EV_NUM = 33'd1 << 18,
    S_EV_DIV = 33'd1 << 19,
    S_EV_IDX = 33'd1 << 20,
    S_EV_IXW = 33'd1 << 21,
    S_EV_W   = 33'd1 << 22,
    S_EV_SY  = 33'd1 << 23,
    S_EV_SD  = 33'd1 << 24,
    S_EV_WL  = 33'd1 << 25,
    S_EV_WH  = 33'd1 << 26,
    S_EV_WA  = 33'd1 << 27,
    S_EV_FIN = 33'd1 << 28,
    S_EV_A1  = 33'd1 << 29,
    S_EV_B0  = 33'd1 << 30,
    S_EV_B1  = 33'd1 << 31,
    S_EV_CMP = 33'd1 << 32
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]  num_r, n_eff;
  logic [SIZE_W-1:0] fw_r, fh_r, w_eff, h_eff;
  logic [NUM_W-1:0]  loaded_r, slot_r, j_r, p_r, k_r;
  logic [47:0]       pair_sum_r;
  entry_t            cur_r;
  logic [63:0]       t_r;
  logic [27:0]       w2_r, h2_r;
  logic [55:0]       den_r;
  logic [10:0]       pairs_r;
  logic [56:0]       num_acc_r, rem_r, nsum, r2;
  logic [31:0]       f_r;
  logic [4:0]        cnt_r;
  logic [WGT_W-1:0]  w_r;
  logic [34:0]       dist_r;
  logic [57:0]       s_r;
  logic [21:0]       sw_r;
  logic [71:0]       acc_a_r, acc_b;
  logic [49:0]       ps4;
  logic              out_tvalid_r, out_bad_r, out_last_r, verdict_bad, ev_out;
  logic [IDX_W-1:0]  out_idx_r;
  logic              k_last, p_last, cfg_wr, out_free;
  logic [NUM_W-1:0]  slot_in;

  entry_t            in_entry, rdata;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mul_p;
  logic [WGT_W-1:0]  rom_q;

  assign in_entry = entry_t'(in_tdata[ENTRY_W-1:0]);
  assign n_eff = (num_r == '0) ? NUM_W'(1) :
                 (num_r > NUM_W'(MAX_PATCHES)) ? NUM_W'(MAX_PATCHES) : num_r;
  assign w_eff = (fw_r == '0) ? SIZE_W'(1) : fw_r;
  assign h_eff = (fh_r == '0) ? SIZE_W'(1) : fh_r;
  assign slot_in = (loaded_r >= n_eff) ? '0 : loaded_r;
  assign k_last = (k_r + NUM_W'(1)) == n_eff;
  assign p_last = (p_r + NUM_W'(1)) == n_eff;
  assign nsum = num_acc_r + 57'(mul_p);
  assign r2 = {rem_r[55:0], 1'b0};
  assign ps4 = {pair_sum_r, 2'b00};
  assign acc_b = 72'(t_r) + {mul_p[39:0], 32'd0};
  assign out_free = !out_tvalid_r || out_tready;
  assign ev_out = (state_r == S_EV_CMP) || ((state_r == S_EV_FIN) &&
                  ((pairs_r == '0) || (sw_r == '0)));

  assign in_tready  = (state_r == S_IDLE);
  assign mem_we     = in_tvalid && in_tready;

  lopd_mem #(.DEPTH(MAX_PATCHES), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(slot_in[AW-1:0]), .wdata(in_entry),
    .re(mem_re), .raddr(mem_raddr), .rdata_r(rdata)
  );

  lopd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  lopd_wrom #(.DEPTH(WEIGHT_TABLE_DEPTH), .AW(IW)) u_wrom (
    .clk(clk), .addr(mul_p[32 +: IW]), .q_r(rom_q)
  );

  // read port and multiplier operand selection
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = j_r[AW-1:0];
    mul_a     = '0;
    mul_b     = '0;
    unique case (state_r)
      S_LD_RD: begin
        mem_re = 1'b1;
      end
      S_LD_MX: begin
        mul_a = 32'(shift_mag(cur_r.sx, rdata.sx));
        mul_b = mul_a;
      end
      S_LD_MY: begin
        mul_a = 32'(shift_mag(cur_r.sy, rdata.sy));
        mul_b = mul_a;
      end
      S_SU_W: begin
        mul_a = 32'(w_eff);
        mul_b = 32'(w_eff);
      end
      S_SU_H: begin
        mul_a = 32'(h_eff);
        mul_b = 32'(h_eff);
      end
      S_SU_D: begin
        mul_a = 32'(w2_r);
        mul_b = 32'(mul_p[27:0]);
      end
      S_SU_P: begin
        mul_a = 32'(n_eff);
        mul_b = 32'(n_eff - NUM_W'(1));
      end
      S_EV_P: begin
        mem_re    = 1'b1;
        mem_raddr = p_r[AW-1:0];
      end
      S_EV_K: begin
        mem_re    = (k_r != p_r);
        mem_raddr = k_r[AW-1:0];
      end
      S_EV_DX: begin
        mul_a = 32'(size_mag(cur_r.cx, rdata.cx));
        mul_b = mul_a;
      end
      S_EV_DY: begin
        mul_a = 32'(size_mag(cur_r.cy, rdata.cy));
        mul_b = mul_a;
      end
      S_EV_NX: begin
        mul_a = t_r[31:0];
        mul_b = 32'(h2_r);
      end
      S_EV_NY: begin
        mul_a = t_r[31:0];
        mul_b = 32'(w2_r);
      end
      S_EV_IDX: begin
        mul_a = f_r;
        mul_b = SCALE;
      end
      S_EV_W: begin
        mul_a = 32'(shift_mag(cur_r.sx, rdata.sx));
        mul_b = mul_a;
      end
      S_EV_SY: begin
        mul_a = 32'(shift_mag(cur_r.sy, rdata.sy));
        mul_b = mul_a;
      end
      S_EV_WL: begin
        mul_a = 32'(w_r);
        mul_b = dist_r[31:0];
      end
      S_EV_WH: begin
        mul_a = 32'(w_r);
        mul_b = 32'(dist_r[34:32]);
      end
      S_EV_FIN: begin
        mul_a = s_r[31:0];
        mul_b = 32'(pairs_r);
      end
      S_EV_A1: begin
        mul_a = 32'(s_r[57:32]);
        mul_b = 32'(pairs_r);
      end
      S_EV_B0: begin
        mul_a = ps4[31:0];
        mul_b = 32'(sw_r);
      end
      S_EV_B1: begin
        mul_a = 32'(ps4[49:32]);
        mul_b = 32'(sw_r);
      end
      // hold the high product while the verdict waits for the output register
      S_EV_CMP: begin
        mul_a = 32'(ps4[49:32]);
        mul_b = 32'(sw_r);
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (mem_we) state_nxt = (slot_in == '0) ? S_LD_END : S_LD_RD;
      S_LD_RD:  state_nxt = S_LD_MX;
      S_LD_MX:  state_nxt = S_LD_MY;
      S_LD_MY:  state_nxt = S_LD_ACC;
      S_LD_ACC: state_nxt = ((j_r + NUM_W'(1)) == slot_r) ? S_LD_END : S_LD_RD;
      S_LD_END: state_nxt = ((slot_r + NUM_W'(1)) < n_eff) ? S_IDLE : S_SU_W;
      S_SU_W:   state_nxt = S_SU_H;
      S_SU_H:   state_nxt = S_SU_D;
      S_SU_D:   state_nxt = S_SU_P;
      S_SU_P:   state_nxt = S_SU_END;
      S_SU_END: state_nxt = S_EV_P;
      S_EV_P:   state_nxt = S_EV_PL;
      S_EV_PL:  state_nxt = S_EV_K;
      S_EV_K: begin
        if (k_r != p_r) state_nxt = S_EV_DX;
        else if (k_last) state_nxt = S_EV_FIN;
      end
      S_EV_DX:  state_nxt = S_EV_DY;
      S_EV_DY:  state_nxt = S_EV_NX;
      S_EV_NX:  state_nxt = S_EV_NY;
      S_EV_NY:  state_nxt = S_EV_NUM;
      S_EV_NUM: begin
        if (nsum >= 57'(den_r)) state_nxt = k_last ? S_EV_FIN : S_EV_K;
        else state_nxt = S_EV_DIV;
      end
      S_EV_DIV: if (cnt_r == 5'd31) state_nxt = S_EV_IDX;
      S_EV_IDX: begin
        if (f_r >= (32'd1 << 29)) state_nxt = k_last ? S_EV_FIN : S_EV_K;
        else state_nxt = S_EV_IXW;
      end
      S_EV_IXW: begin
        if (mul_p[63:32] >= WDEPTH) state_nxt = k_last ? S_EV_FIN : S_EV_K;
        else state_nxt = S_EV_W;
      end
      S_EV_W:   state_nxt = S_EV_SY;
      S_EV_SY:  state_nxt = S_EV_SD;
      S_EV_SD:  state_nxt = S_EV_WL;
      S_EV_WL:  state_nxt = S_EV_WH;
      S_EV_WH:  state_nxt = S_EV_WA;
      S_EV_WA:  state_nxt = k_last ? S_EV_FIN : S_EV_K;
      S_EV_FIN: begin
        if (ev_out) begin
          if (out_free) state_nxt = p_last ? S_IDLE : S_EV_P;
        end else begin
          state_nxt = S_EV_A1;
        end
      end
      S_EV_A1:  state_nxt = S_EV_B0;
      S_EV_B0:  state_nxt = S_EV_B1;
      S_EV_B1:  state_nxt = S_EV_CMP;
      S_EV_CMP: if (out_free) state_nxt = p_last ? S_IDLE : S_EV_P;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign verdict_bad = (state_r == S_EV_CMP) ? !(acc_a_r < acc_b) : 1'b1;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_r        <= NUM_W'(1);
      fw_r         <= SIZE_W'(4096);
      fh_r         <= SIZE_W'(4096);
      loaded_r     <= '0;
      pair_sum_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ev_out && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      if (mem_we && (loaded_r >= n_eff)) pair_sum_r <= '0;
      if (state_r == S_LD_ACC) begin
        pair_sum_r <= pair_sum_r + 48'(t_r[33:0]) + 48'(mul_p[33:0]);
      end
      if (state_r == S_LD_END) loaded_r <= slot_r + NUM_W'(1);
      if (ev_out && out_free && p_last) begin
        loaded_r   <= '0;
        pair_sum_r <= '0;
      end
      if (cfg_wr) begin
        unique case (cfg_paddr[3:2])
          REG_NUM_PATCHES: begin
            num_r      <= cfg_pwdata[NUM_W-1:0];
            loaded_r   <= '0;
            pair_sum_r <= '0;
          end
          REG_FRAME_WIDTH:  fw_r <= cfg_pwdata[SIZE_W-1:0];
          REG_FRAME_HEIGHT: fh_r <= cfg_pwdata[SIZE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cur_r  <= in_entry;
      slot_r <= slot_in;
      j_r    <= '0;
    end
    unique case (state_r)
      S_LD_MY:  t_r <= mul_p;
      S_LD_ACC: j_r <= j_r + NUM_W'(1);
      S_SU_H:   w2_r <= mul_p[27:0];
      S_SU_D:   h2_r <= mul_p[27:0];
      S_SU_P:   den_r <= mul_p[55:0];
      S_SU_END: begin
        pairs_r <= mul_p[11:1];
        p_r     <= '0;
      end
      S_EV_PL: begin
        cur_r <= rdata;
        k_r   <= '0;
        s_r   <= '0;
        sw_r  <= '0;
      end
      S_EV_K:   if (k_r == p_r) k_r <= k_r + NUM_W'(1);
      S_EV_DY:  t_r <= mul_p;
      S_EV_NX:  t_r <= mul_p;
      S_EV_NY:  num_acc_r <= 57'(mul_p[55:0]);
      S_EV_NUM: begin
        rem_r <= nsum;
        f_r   <= '0;
        cnt_r <= '0;
        if (nsum >= 57'(den_r)) k_r <= k_r + NUM_W'(1);
      end
      S_EV_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        if (r2 >= 57'(den_r)) begin
          rem_r <= r2 - 57'(den_r);
          f_r   <= {f_r[30:0], 1'b1};
        end else begin
          rem_r <= r2;
          f_r   <= {f_r[30:0], 1'b0};
        end
      end
      S_EV_IDX: if (f_r >= (32'd1 << 29)) k_r <= k_r + NUM_W'(1);
      S_EV_IXW: if (mul_p[63:32] >= WDEPTH) k_r <= k_r + NUM_W'(1);
      S_EV_W:   w_r <= rom_q;
      S_EV_SY:  t_r <= mul_p;
      S_EV_SD:  dist_r <= t_r[34:0] + 35'(mul_p[33:0]);
      S_EV_WH:  t_r <= mul_p;
      S_EV_WA: begin
        s_r  <= s_r + 58'(t_r) + {26'(mul_p), 32'd0};
        sw_r <= sw_r + 22'(w_r);
        k_r  <= k_r + NUM_W'(1);
      end
      S_EV_A1:  t_r <= mul_p;
      S_EV_B0:  acc_a_r <= 72'(t_r) + {mul_p[39:0], 32'd0};
      S_EV_B1:  t_r <= mul_p;
      default: begin
      end
    endcase
    if (ev_out && out_free) begin
      out_idx_r  <= IDX_W'(p_r);
      out_bad_r  <= verdict_bad;
      out_last_r <= p_last;
      p_r        <= p_r + NUM_W'(1);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_NUM_PATCHES:  cfg_prdata = 32'(num_r);
      REG_FRAME_WIDTH:  cfg_prdata = 32'(fw_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(fh_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_bad_r, out_idx_r};
  assign out_tlast  = out_last_r;

  `LOPD_ASSERT_CLK(a_busy_after_load, in_tvalid && in_tready |=> !in_tready, "ready after load")
  `LOPD_ASSERT_CLK(a_div_rem, (state_r == S_EV_DIV) |-> (rem_r < 57'(den_r)), "divider remainder")
  `LOPD_ASSERT_CLK(a_k_range, (state_r == S_EV_K) |-> (k_r < n_eff), "pair index overrun")
  `LOPD_ASSERT_CLK(a_out_src, $rose(out_tvalid) |-> $past(ev_out), "result without verdict")
endmodule
`default_nettype wire

// ----- design/lopd_mul.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
`default_nettype none
module lopd_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end
endmodule
`default_nettype wire

// ----- design/lopd_mem.sv -----
// Patch store: one write port, one registered read port.
`default_nettype none
module lopd_mem
  import lopd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata_r
);
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- design/lopd_wrom.sv -----
// Weight table exp(-12.5*i/DEPTH) in Q0.16, registered read.
`default_nettype none
module lopd_wrom
  import lopd_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    addr,
  output logic      [WGT_W-1:0] q_r
);
  logic [WGT_W-1:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [63:0] XI = ((64'd25 * 64'(i)) << 30) / (2 * DEPTH);
    assign rom[i] = build_weight(XI);
  end

  always_ff @(posedge clk) begin
    q_r <= rom[addr];
  end
endmodule
`default_nettype wire
